FILE: hdl/sfa_pkg.sv
// Shared types and constants of the stack frame allocator.
`default_nettype none

package sfa_pkg;

   localparam int BYTES_W  = 17;
   localparam int LIMIT_W  = 7;
   localparam int FRAME_W  = 6;
   localparam int OFFSET_W = 16;

   localparam logic [BYTES_W-1:0] TOTAL_BYTES_RESET = 17'h10000;
   localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RESET = 7'd64;

   typedef enum logic [1:0] {
      KIND_ALLOC      = 2'd0,
      KIND_FREE_INDEX = 2'd1,
      KIND_FREE_ADDR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SPACE   = 2'd1,
      STATUS_TABLE_FULL = 2'd2,
      STATUS_NO_MATCH   = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      CSR_TOTAL_BYTES = 1'b0,
      CSR_FRAME_LIMIT = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      RD_SCAN  = 2'd0,
      RD_TOP   = 2'd1,
      RD_BELOW = 2'd2
   } rd_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEARCH_START,
      ST_SEARCH,
      ST_CLEAR,
      ST_POP_START,
      ST_POP
   } state_type;

   typedef struct packed {
      kind_type              kind;
      logic [BYTES_W-1:0]    request_bytes;
      logic [FRAME_W-1:0]    frame_number;
      logic [OFFSET_W-1:0]   byte_address;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [FRAME_W-1:0]    granted_frame;
      logic [BYTES_W-1:0]    granted_offset;
      logic [BYTES_W-1:0]    top_after;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       latch_req;
      logic       alloc_commit;
      logic       clear_busy;
      logic       scan_reset;
      logic       scan_step;
      logic       pop_step;
      rd_src_type rd_src;
      logic       done;
      status_type status;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     no_space;
      logic     table_full;
      logic     index_bad;
      logic     hit;
      logic     scan_end;
      logic     live_zero;
      logic     live_one;
      logic     top_busy;
   } flags_type;

endpackage

`default_nettype wire

FILE: hdl/sfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sfa_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 64,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/sfa_ctrl.sv
// Controller state machine that sequences allocate, search and pop steps.
`default_nettype none

module sfa_ctrl
   import sfa_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      start,
   output logic           busy,
   output logic           rsp_valid,
   input  wire flags_type flags,
   output cmd_type        cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '{rd_src: RD_SCAN, status: STATUS_OK, default: 1'b0};
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (flags.kind)
               KIND_ALLOC: begin
                  cmd.done = 1'b1;
                  state_in = ST_IDLE;
                  if (flags.no_space) begin
                     cmd.status = STATUS_NO_SPACE;
                  end else if (flags.table_full) begin
                     cmd.status = STATUS_TABLE_FULL;
                  end else begin
                     cmd.alloc_commit = 1'b1;
                  end
               end
               KIND_FREE_INDEX: begin
                  if (flags.index_bad) begin
                     cmd.done   = 1'b1;
                     cmd.status = STATUS_NO_MATCH;
                     state_in   = ST_IDLE;
                  end else begin
                     state_in = ST_CLEAR;
                  end
               end
               KIND_FREE_ADDR: begin
                  cmd.scan_reset = 1'b1;
                  state_in       = ST_SEARCH_START;
               end
               default: begin
                  cmd.done   = 1'b1;
                  cmd.status = STATUS_NO_MATCH;
                  state_in   = ST_IDLE;
               end
            endcase
         end
         ST_SEARCH_START: begin
            if (flags.live_zero) begin
               cmd.done   = 1'b1;
               cmd.status = STATUS_NO_MATCH;
               state_in   = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
               state_in      = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (flags.hit) begin
               state_in = ST_CLEAR;
            end else if (flags.scan_end) begin
               cmd.done   = 1'b1;
               cmd.status = STATUS_NO_MATCH;
               state_in   = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_CLEAR: begin
            cmd.clear_busy = 1'b1;
            state_in       = ST_POP_START;
         end
         ST_POP_START: begin
            if (flags.live_zero) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.rd_src = RD_TOP;
               state_in   = ST_POP;
            end
         end
         ST_POP: begin
            if (flags.top_busy) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cmd.pop_step = 1'b1;
               cmd.rd_src   = RD_BELOW;
               if (flags.live_one) begin
                  cmd.done = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.done;
   assign rsp_valid    = rsp_valid_ff;
   assign busy         = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: hdl/sfa_datapath.sv
// Datapath: configuration, top and count registers, frame tables and compares.
`default_nettype none

module sfa_datapath
   import sfa_pkg::*;
#(
   parameter int MAX_FRAMES = 64,
   parameter int ADDR_BITS  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output flags_type                flags,
   input  wire req_type             req_data,
   input  wire logic                csr_write,
   input  wire csr_reg_type         csr_index,
   input  wire logic [BYTES_W-1:0]  csr_data,
   output rsp_type                  rsp_data
);

   localparam int IDX_W = $clog2(MAX_FRAMES);
   localparam int CNT_W = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int FN_W  = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
   localparam logic [OFFSET_W-1:0] ADDR_MASK = (ADDR_BITS >= OFFSET_W) ?
      {OFFSET_W{1'b1}} : OFFSET_W'((64'd1 << ADDR_BITS) - 64'd1);

   logic [BYTES_W-1:0] total_ff, total_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [BYTES_W-1:0] top_ff, top_in;
   logic [CNT_W-1:0]   live_ff, live_in;
   req_type            req_ff;
   logic [CNT_W-1:0]   scan_ff;
   status_type         status_ff;
   logic [FRAME_W-1:0] gframe_ff;
   logic [BYTES_W-1:0] goff_ff;

   logic [BYTES_W:0]   alloc_sum;
   logic [CNT_W-1:0]   live_m1, live_m2, scan_m1;
   logic [IDX_W-1:0]   rd_addr, clr_idx, live_idx, busy_addr;
   logic [BYTES_W-1:0] start_rd, bytes_rd;
   logic [0:0]         busy_rd;
   logic [BYTES_W:0]   ext_addr, ext_start, frame_end;

   assign alloc_sum = {1'b0, top_ff} + {1'b0, req_ff.request_bytes};
   assign live_m1   = live_ff - CNT_W'(1);
   assign live_m2   = live_ff - CNT_W'(2);
   assign scan_m1   = scan_ff - CNT_W'(1);
   assign live_idx  = live_ff[IDX_W-1:0];
   assign clr_idx   = (req_ff.kind == KIND_FREE_INDEX) ?
                      IDX_W'(req_ff.frame_number) : scan_m1[IDX_W-1:0];

   always_comb begin
      case (cmd.rd_src)
         RD_TOP:   rd_addr = live_m1[IDX_W-1:0];
         RD_BELOW: rd_addr = live_m2[IDX_W-1:0];
         default:  rd_addr = scan_ff[IDX_W-1:0];
      endcase
   end

   always_comb begin
      total_in = total_ff;
      limit_in = limit_ff;
      top_in   = top_ff;
      live_in  = live_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TOTAL_BYTES: total_in = csr_data;
            CSR_FRAME_LIMIT: limit_in = csr_data[LIMIT_W-1:0];
         endcase
      end
      if (cmd.alloc_commit) begin
         top_in  = alloc_sum[BYTES_W-1:0];
         live_in = live_ff + CNT_W'(1);
      end else if (cmd.pop_step) begin
         top_in  = top_ff - bytes_rd;
         live_in = live_m1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_BYTES_RESET;
         limit_ff <= FRAME_LIMIT_RESET;
         top_ff   <= '0;
         live_ff  <= '0;
      end else begin
         total_ff <= total_in;
         limit_ff <= limit_in;
         top_ff   <= top_in;
         live_ff  <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_ff    <= req_data;
         gframe_ff <= '0;
         goff_ff   <= '0;
      end else if (cmd.alloc_commit) begin
         gframe_ff <= FRAME_W'(live_ff);
         goff_ff   <= top_ff;
      end
      if (cmd.scan_reset) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end
      if (cmd.done) begin
         status_ff <= cmd.status;
      end
   end

   sfa_ram #(.WIDTH(BYTES_W), .DEPTH(MAX_FRAMES)) u_start_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit),
      .wr_addr (live_idx),
      .wr_data (top_ff),
      .rd_addr (rd_addr),
      .rd_data (start_rd)
   );

   sfa_ram #(.WIDTH(BYTES_W), .DEPTH(MAX_FRAMES)) u_bytes_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit),
      .wr_addr (live_idx),
      .wr_data (req_ff.request_bytes),
      .rd_addr (rd_addr),
      .rd_data (bytes_rd)
   );

   assign busy_addr = cmd.alloc_commit ? live_idx : clr_idx;

   sfa_ram #(.WIDTH(1), .DEPTH(MAX_FRAMES)) u_busy_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit | cmd.clear_busy),
      .wr_addr (busy_addr),
      .wr_data (cmd.alloc_commit),
      .rd_addr (rd_addr),
      .rd_data (busy_rd)
   );

   // A frame holds an address equal to its start or strictly inside its range.
   assign ext_addr  = {2'b00, req_ff.byte_address & ADDR_MASK};
   assign ext_start = {1'b0, start_rd};
   assign frame_end = {1'b0, start_rd} + {1'b0, bytes_rd};

   always_comb begin
      flags.kind       = req_ff.kind;
      flags.no_space   = alloc_sum > {1'b0, total_ff};
      flags.table_full = (LIM_W'(live_ff) >= LIM_W'(limit_ff)) ||
                         (live_ff >= CNT_W'(MAX_FRAMES));
      flags.index_bad  = FN_W'(req_ff.frame_number) >= FN_W'(live_ff);
      flags.hit        = (ext_addr == ext_start) ||
                         ((ext_addr > ext_start) && (ext_addr < frame_end));
      flags.scan_end   = (scan_ff == live_ff);
      flags.live_zero  = (live_ff == '0);
      flags.live_one   = (live_ff == CNT_W'(1));
      flags.top_busy   = busy_rd[0];
   end

   assign rsp_data.status         = status_ff;
   assign rsp_data.granted_frame  = gframe_ff;
   assign rsp_data.granted_offset = goff_ff;
   assign rsp_data.top_after      = top_ff;

endmodule

`default_nettype wire

FILE: hdl/stack_frame_allocator_core.sv
// Top level of the stack frame allocator: controller, datapath and config port.
// Allocate, a bad index and an unused kind answer straight from decode; free by index clears
// the frame and then pops the free frames off the top, and free by address first searches
// the frames from the bottom for a hit; a failed search answers when it reaches the top.
// One request at a time; the next beat is taken in the cycle its result shows, and the
// receiver cannot stall. Synchronous reset restores top, count and config; no clear pass.
`default_nettype none

module stack_frame_allocator_core
   import sfa_pkg::*;
#(
   parameter int MAX_FRAMES = 64,
   parameter int ADDR_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel: a beat is taken when start is high and busy is low.
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_data,
   // Result channel: one strobed beat per request; the receiver cannot stall.
   output logic                    rsp_valid,
   output rsp_type                 rsp_data,
   // Configuration write channel.
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire csr_reg_type        csr_index,
   input  wire logic [BYTES_W-1:0] csr_data
);

   cmd_type   cmd;
   flags_type flags;
   logic      csr_write;

   // Registers may only change while no request is in flight.
   assign csr_ready = ~busy;
   assign csr_write = csr_valid & csr_ready;

   sfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .flags     (flags),
      .cmd       (cmd)
   );

   sfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .ADDR_BITS  (ADDR_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .flags     (flags),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_data  (rsp_data)
   );

   // Each request gives exactly one result beat, one cycle wide.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   // An accepted request keeps the block busy and cannot answer in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted request did not enter the busy phase");

   // Only a successful allocate reports a granted frame and offset.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != STATUS_OK)) |->
      ((rsp_data.granted_frame == '0) && (rsp_data.granted_offset == '0)))
      else $error("grant fields set on a refused request");

endmodule

`default_nettype wire

FILE: bench/frame_ledger_pkg.sv
// Scoreboard class that predicts the stack frame allocator and checks its result beats.
package frame_ledger_pkg;
   import sfa_pkg::*;

   // Depth of the frame table; the bench builds the block with the same value.
   localparam int TABLE_DEPTH = 64;

   class frame_ledger;
      logic [BYTES_W-1:0] total_bytes;
      logic [LIMIT_W-1:0] frame_limit;
      logic [BYTES_W-1:0] start_of [TABLE_DEPTH];
      logic [BYTES_W-1:0] size_of [TABLE_DEPTH];
      bit                 held [TABLE_DEPTH];
      logic [BYTES_W-1:0] top;
      logic [LIMIT_W-1:0] live;
      rsp_type            owed [$];
      int                 errors;

      function new();
         total_bytes = TOTAL_BYTES_RESET;
         frame_limit = FRAME_LIMIT_RESET;
         top = '0;
         live = '0;
         errors = 0;
         foreach (held[i]) begin
            held[i] = 1'b0;
            start_of[i] = '0;
            size_of[i] = '0;
         end
      endfunction

      function void log_mismatch(string msg);
         errors++;
         if (errors <= 10)
            $display("MISMATCH at %0t: %s", $realtime, msg);
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void note_config(csr_reg_type idx, logic [BYTES_W-1:0] value);
         case (idx)
            CSR_TOTAL_BYTES: total_bytes = value;
            CSR_FRAME_LIMIT: frame_limit = value[LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      // Trailing frames that are no longer held come off the stack.
      function void pop_free_tail();
         while (live != 0 && !held[live - 1]) begin
            top = top - size_of[live - 1];
            live = live - 1'b1;
         end
      endfunction

      function status_type release_frame(int idx);
         if (idx >= live)
            return STATUS_NO_MATCH;
         held[idx] = 1'b0;
         pop_free_tail();
         return STATUS_OK;
      endfunction

      function void note_request(req_type r);
         rsp_type          reply;
         logic [BYTES_W:0] reach;
         logic [BYTES_W:0] span_end;
         int               limit;
         reply = '0;
         reply.status = STATUS_NO_MATCH;
         case (r.kind)
            KIND_ALLOC: begin
               limit = (frame_limit < TABLE_DEPTH) ? frame_limit : TABLE_DEPTH;
               reach = {1'b0, top} + {1'b0, r.request_bytes};
               if (reach > {1'b0, total_bytes}) begin
                  reply.status = STATUS_NO_SPACE;
               end else if (live >= limit) begin
                  reply.status = STATUS_TABLE_FULL;
               end else begin
                  start_of[live] = top;
                  size_of[live] = r.request_bytes;
                  held[live] = 1'b1;
                  reply.granted_frame = live[FRAME_W-1:0];
                  reply.granted_offset = top;
                  top = reach[BYTES_W-1:0];
                  live = live + 1'b1;
                  reply.status = STATUS_OK;
               end
            end
            KIND_FREE_INDEX: begin
               reply.status = release_frame(r.frame_number);
            end
            KIND_FREE_ADDR: begin
               for (int i = 0; i < live; i++) begin
                  span_end = {1'b0, start_of[i]} + {1'b0, size_of[i]};
                  if (r.byte_address == start_of[i] ||
                      (r.byte_address > start_of[i] && r.byte_address < span_end)) begin
                     reply.status = release_frame(i);
                     break;
                  end
               end
            end
            default: ;
         endcase
         reply.top_after = top;
         owed.push_back(reply);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            log_mismatch($sformatf("result beat with nothing expected (status %0d, top %0d)",
                                   got.status, got.top_after));
            return;
         end
         want = owed.pop_front();
         if (got.status !== want.status)
            log_mismatch($sformatf("status: expected %0d, got %0d", want.status, got.status));
         if (got.granted_frame !== want.granted_frame)
            log_mismatch($sformatf("granted_frame: expected %0d, got %0d",
                                   want.granted_frame, got.granted_frame));
         if (got.granted_offset !== want.granted_offset)
            log_mismatch($sformatf("granted_offset: expected %0d, got %0d",
                                   want.granted_offset, got.granted_offset));
         if (got.top_after !== want.top_after)
            log_mismatch($sformatf("top_after: expected %0d, got %0d",
                                   want.top_after, got.top_after));
      endfunction
   endclass

endpackage

FILE: bench/stack_frame_allocator_core_tb.sv
// Self-checking bench for the stack frame allocator core: directed and random requests.
module stack_frame_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfa_pkg::*;
   import frame_ledger_pkg::*;

   // The request kind that the block must ignore has no member in the package enum.
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Longest legal quiet stretch is a full address search plus a full pop walk
   // after the longest sender gap, so this limit is generous.
   localparam int WATCHDOG_LIMIT = 3000;
   // Cycles to keep watching after the last expected beat for stray results.
   localparam int TAIL_CYCLES = 200;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   csr_reg_type        csr_index = CSR_TOTAL_BYTES;
   logic [BYTES_W-1:0] csr_data = '0;

   frame_ledger ledger;
   int          quiet_cycles = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stack_frame_allocator_core #(
      .MAX_FRAMES(TABLE_DEPTH),
      .ADDR_BITS (16)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // Every result beat lives for exactly one cycle and cannot be held off, so the
   // monitor samples it at each rising edge. Values read here are the ones that
   // were settled before the edge, since the block updates through its flops.
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         ledger.check_reply(rsp_data);
   end

   // The watchdog is cleared by any accepted beat on any channel. A block that
   // hangs, or one that drops a result, lets it run out.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Present one request and hold it until an edge finds the block not busy.
   // The prediction is made at that edge, so the next request is built from
   // the state the block will have once this one is done.
   task automatic send_request(input req_type r);
      start <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (!busy)
            break;
      end
      ledger.note_request(r);
   endtask

   // Sender gap. Start is lowered here and raised again only at a later edge.
   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the sender off until every predicted result beat has arrived. At
   // least one edge passes, so the caller never touches start in this step.
   task automatic drain();
      start <= 1'b0;
      forever begin
         @(posedge clock);
         if (ledger.pending() == 0)
            break;
      end
   endtask

   // Both registers go out back to back with valid held high between them.
   // Only ever called while the block is idle.
   task automatic configure(input logic [BYTES_W-1:0] total, input logic [LIMIT_W-1:0] limit);
      csr_valid <= 1'b1;
      csr_index <= CSR_TOTAL_BYTES;
      csr_data <= total;
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      ledger.note_config(CSR_TOTAL_BYTES, total);
      csr_index <= CSR_FRAME_LIMIT;
      csr_data <= BYTES_W'(limit);
      forever begin
         @(posedge clock);
         if (csr_ready)
            break;
      end
      ledger.note_config(CSR_FRAME_LIMIT, BYTES_W'(limit));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type make_req(kind_type kind, int bytes, int frame, int addr);
      req_type r;
      r.kind = kind;
      r.request_bytes = BYTES_W'(bytes);
      r.frame_number = FRAME_W'(frame);
      r.byte_address = OFFSET_W'(addr);
      return r;
   endfunction

   // Random request aimed at the live stack: frees mostly name a frame that
   // exists or an address that falls inside one, and allocations are sized
   // against the store size or the room left, so the pop walk and the search get real work.
   // All fields are randomized first, including those the kind ignores.
   function automatic req_type pick_request();
      req_type            r;
      int                 roll;
      int                 pick;
      logic [BYTES_W-1:0] room;
      r.kind = KIND_ALLOC;
      r.request_bytes = BYTES_W'($urandom_range(0, 65536));
      r.frame_number = FRAME_W'($urandom);
      r.byte_address = OFFSET_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         room = (ledger.total_bytes > ledger.top) ? ledger.total_bytes - ledger.top : '0;
         case ($urandom_range(0, 9))
            0: r.request_bytes = '0;
            1: ;
            2: r.request_bytes = room;
            default: r.request_bytes = BYTES_W'($urandom_range(0, ledger.total_bytes / 16 + 1));
         endcase
      end else if (roll < 65) begin
         r.kind = KIND_FREE_INDEX;
         if (ledger.live != 0 && $urandom_range(0, 4) != 0)
            r.frame_number = FRAME_W'($urandom_range(0, ledger.live - 1));
      end else if (roll < 93) begin
         r.kind = KIND_FREE_ADDR;
         if (ledger.live != 0 && $urandom_range(0, 9) < 8) begin
            pick = $urandom_range(0, ledger.live - 1);
            // Now and then aim one past the end, which belongs to the next frame
            // or to no frame at all; for an empty frame it is its own start.
            if ($urandom_range(0, 7) == 0)
               r.byte_address = OFFSET_W'(ledger.start_of[pick] + ledger.size_of[pick]);
            else if (ledger.size_of[pick] == 0)
               r.byte_address = OFFSET_W'(ledger.start_of[pick]);
            else
               r.byte_address = OFFSET_W'(ledger.start_of[pick] +
                                          $urandom_range(0, ledger.size_of[pick] - 1));
         end
      end else begin
         r.kind = kind_type'(KIND_SPARE);
      end
      return r;
   endfunction

   // Random traffic in bursts. Short gaps land while the block is still
   // searching or popping, long ones let it go idle, and now and then the
   // sender waits for every outstanding result before going on.
   task automatic run_phase(input int items);
      int sent = 0;
      int burst;
      while (sent < items) begin
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         for (int n = 0; n < burst && sent < items; n++) begin
            send_request(pick_request());
            sent++;
         end
         case ($urandom_range(0, 9))
            0: drain();
            1, 2: pause($urandom_range(20, 90));
            default: pause($urandom_range(1, 8));
         endcase
      end
   endtask

   initial begin
      ledger = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Write the reset values once so that both registers see a write early.
      configure(TOTAL_BYTES_RESET, FRAME_LIMIT_RESET);

      // Zero-size frame below a real one: an address search for offset 0 hits
      // the empty frame first, and a second hit frees a frame already free.
      send_request(make_req(KIND_ALLOC, 0, 0, 0));
      send_request(make_req(KIND_ALLOC, 100, 0, 0));
      send_request(make_req(KIND_FREE_ADDR, 0, 0, 0));
      send_request(make_req(KIND_FREE_ADDR, 0, 0, 0));
      // Freeing the top frame pops both, taking the top back to zero.
      send_request(make_req(KIND_FREE_ADDR, 0, 0, 99));
      // Empty stack: index out of range, address with no frame, unused kind.
      send_request(make_req(KIND_FREE_INDEX, 0, 0, 0));
      send_request(make_req(KIND_FREE_ADDR, 0, 0, 0));
      send_request(make_req(kind_type'(KIND_SPARE), 65536, 63, 65535));
      // Fill the whole store, then a zero-size frame right at the end fits and
      // one more byte does not.
      send_request(make_req(KIND_ALLOC, 65536, 0, 0));
      send_request(make_req(KIND_ALLOC, 0, 0, 0));
      send_request(make_req(KIND_ALLOC, 1, 0, 0));
      send_request(make_req(KIND_FREE_INDEX, 0, 63, 0));
      send_request(make_req(KIND_FREE_ADDR, 0, 0, 65535));
      send_request(make_req(KIND_FREE_INDEX, 0, 1, 0));
      drain();

      // Table full, and then a request that fails on space while the table is
      // also full: the space check takes precedence.
      configure(17'd30, 7'd2);
      send_request(make_req(KIND_ALLOC, 10, 0, 0));
      send_request(make_req(KIND_ALLOC, 10, 0, 0));
      send_request(make_req(KIND_ALLOC, 5, 0, 0));
      send_request(make_req(KIND_ALLOC, 11, 0, 0));
      drain();

      // Store shrunk below the current top: even a zero-size request is refused
      // for space. A frame limit of zero refuses the next allocation even once it fits.
      configure(17'd10, 7'd0);
      send_request(make_req(KIND_ALLOC, 0, 0, 0));
      send_request(make_req(KIND_FREE_INDEX, 0, 1, 0));
      send_request(make_req(KIND_ALLOC, 0, 0, 0));
      drain();

      // Smallest store: one byte fits, a second does not.
      configure(17'd1, 7'd64);
      send_request(make_req(KIND_FREE_INDEX, 0, 0, 0));
      send_request(make_req(KIND_ALLOC, 1, 0, 0));
      send_request(make_req(KIND_ALLOC, 1, 0, 0));
      send_request(make_req(KIND_FREE_ADDR, 0, 0, 0));
      drain();

      // Random phases over a spread of settings. The stack carries over from
      // one phase to the next, so a smaller store often starts below its top.
      configure(17'd65536, 7'd64);
      run_phase(140);
      drain();
      configure(17'd2000, 7'd16);
      run_phase(100);
      drain();
      configure(17'd1, 7'd64);
      run_phase(40);
      drain();
      configure(17'd65536, 7'd0);
      run_phase(40);
      drain();
      configure(17'd500, 7'd5);
      run_phase(100);
      drain();
      configure(17'd40000, 7'd63);
      run_phase(110);
      drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (ledger.pending() != 0)
         ledger.log_mismatch($sformatf("%0d expected results never arrived", ledger.pending()));
      if (ledger.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/sfa_pkg.sv
hdl/sfa_ram.sv
hdl/sfa_ctrl.sv
hdl/sfa_datapath.sv
hdl/stack_frame_allocator_core.sv
bench/frame_ledger_pkg.sv
bench/stack_frame_allocator_core_tb.sv
